// ===== rtl/fdpll_pkg.sv =====
`default_nettype none

package fdpll_pkg;

	// Widths of the time base and of the item fields.
	localparam int TIME_BITS = 32;
	localparam int PERIOD_W  = 13;
	localparam int NOM_W     = 12;
	localparam int TOL_W     = 6;
	localparam int CELLS_W   = 8;
	localparam int BIN_W     = 4;
	localparam int ACTION_W  = 2;
	localparam int IVAL_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 12;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 24;

	// Serial divider: whole cells first, then the slot bits of the remainder.
	localparam int DIV_STEPS = TIME_BITS + BIN_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// One percent of nominal as a reciprocal multiply: floor(n * 1311 / 2^17).
	localparam int STEP_MUL_W = 11;
	localparam logic [STEP_MUL_W-1:0] STEP_MUL = STEP_MUL_W'(1311);
	localparam int STEP_SHIFT = 17;
	localparam int STEP_W     = NOM_W + STEP_MUL_W - STEP_SHIFT;
	localparam int TOLSTEP_W  = TOL_W + STEP_W;

	// Register reset values.
	localparam logic [NOM_W-1:0] NOM_RESET = NOM_W'(200);
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(6);

	// Slot thresholds and counter limits of the loop filter.
	localparam logic [BIN_W-1:0] SLOT_LOCK_LO  = BIN_W'(7);
	localparam logic [BIN_W-1:0] SLOT_LOCK_HI  = BIN_W'(8);
	localparam logic [BIN_W-1:0] SLOT_EARLY_HI = BIN_W'(6);
	localparam logic [BIN_W-1:0] SLOT_LATE_LO  = BIN_W'(9);
	localparam logic [BIN_W-1:0] SLOT_FAR_EARLY = BIN_W'(3);
	localparam logic [BIN_W-1:0] SLOT_FAR_LATE  = BIN_W'(12);
	localparam logic [1:0] COUNT_LIMIT = 2'd3;
	localparam logic [1:0] PHASE_LIMIT = 2'd2;

	// Window edge distance in sixteenths of a cell, weak and strong rows.
	localparam logic [3:0] EDGE_TAB [2][16] = '{
		'{4'd12, 4'd12, 4'd11, 4'd11, 4'd10, 4'd10, 4'd9, 4'd9,
		  4'd8, 4'd8, 4'd7, 4'd7, 4'd6, 4'd6, 4'd5, 4'd5},
		'{4'd13, 4'd13, 4'd12, 4'd12, 4'd11, 4'd11, 4'd10, 4'd9,
		  4'd8, 4'd7, 4'd6, 4'd6, 4'd5, 4'd5, 4'd4, 4'd4}
	};

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_NOMINAL   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_FLUX    = 2'd0,
		ACT_RESTART = 2'd1,
		ACT_SYNC    = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE,
		ST_EDGE
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [TIME_BITS-1:0] dividend;
		logic [PERIOD_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [CELLS_W-1:0] cells;
		logic [BIN_W-1:0]   bin;
	} div_res_t;

	function automatic logic [3:0] edge_mult(input logic row, input logic [BIN_W-1:0] slot);
		edge_mult = EDGE_TAB[row][slot];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fdpll_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The first TIME_BITS bits
// give the whole cells (saturated to eight bits), the last four bits give
// the slot, sixteen times the remainder over the divisor.
module fdpll_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fdpll_pkg::div_req_t req,
	output fdpll_pkg::div_res_t      res
);

	logic                                busy_q;
	logic                                done_q;
	logic [fdpll_pkg::CNT_W-1:0]         cnt_q;
	logic [fdpll_pkg::TIME_BITS-1:0]     dvd_q;
	logic [fdpll_pkg::PERIOD_W-1:0]      div_q;
	logic [fdpll_pkg::PERIOD_W-1:0]      rem_q;
	logic [fdpll_pkg::CELLS_W-1:0]       cells_q;
	logic                                sat_q;
	logic [fdpll_pkg::BIN_W-1:0]         bin_q;

	logic                                int_phase;
	logic                                in_bit;
	logic [fdpll_pkg::PERIOD_W:0]        trial;
	logic [fdpll_pkg::PERIOD_W:0]        diff;
	logic                                q_bit;
	logic [fdpll_pkg::PERIOD_W-1:0]      rem_next;

	// One trial subtraction per cycle.
	always_comb begin
		int_phase = cnt_q < fdpll_pkg::CNT_W'(fdpll_pkg::TIME_BITS);
		in_bit    = int_phase ? dvd_q[fdpll_pkg::TIME_BITS-1] : 1'b0;
		trial     = {rem_q, in_bit};
		diff      = trial - {1'b0, div_q};
		q_bit     = trial >= {1'b0, div_q};
		rem_next  = q_bit ? diff[fdpll_pkg::PERIOD_W-1:0] : trial[fdpll_pkg::PERIOD_W-1:0];
	end

	// Sequencing of the divide.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == fdpll_pkg::CNT_W'(fdpll_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand and quotient shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q   <= req.dividend;
			div_q   <= req.divisor;
			rem_q   <= '0;
			cells_q <= '0;
			sat_q   <= 1'b0;
			bin_q   <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[fdpll_pkg::TIME_BITS-2:0], 1'b0};
			rem_q <= rem_next;
			if (int_phase) begin
				sat_q   <= sat_q | cells_q[fdpll_pkg::CELLS_W-1];
				cells_q <= {cells_q[fdpll_pkg::CELLS_W-2:0], q_bit};
			end else begin
				bin_q <= {bin_q[fdpll_pkg::BIN_W-2:0], q_bit};
			end
		end
	end

	assign res = '{
		done:  done_q,
		cells: sat_q ? {fdpll_pkg::CELLS_W{1'b1}} : cells_q,
		bin:   bin_q
	};

endmodule

`default_nettype wire

// ===== rtl/floppy_flux_dpll.sv =====
`default_nettype none

// Channel   Direction  Payload (lowest bit first)
// s_axis    in         action[1:0], interval[17:2], zero fill to 24 bits
// m_axis    out        empty_cells[7:0], cell_period[20:8], zero fill to 24 bits
// cfg       in         cfg_we, cfg_index (0 nominal, 1 tolerance), cfg_data
//
// A flux interval passes from acceptance through the window check, the
// bit-serial divider (32 whole-cell bits, then 4 slot bits), the hand-over of
// the quotient, the loop filter and the next window edge, which waits for a
// free output register before it writes the result. Restart, sync and unused
// actions give no result; nor does an interval that lands before the window edge.
// A result waits in the output register while the next item is accepted.
// Reset is asynchronous and puts the loop in hunting at the reset nominal cell.
module floppy_flux_dpll (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [fdpll_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // action, interval
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [fdpll_pkg::M_TDATA_W-1:0]       m_axis_tdata,  // empty_cells, cell_period
	input  wire logic                             cfg_we,
	input  wire logic [fdpll_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fdpll_pkg::CFG_DATA_W-1:0] cfg_data
);

	fdpll_pkg::state_t                   state_q, state_d;

	logic [fdpll_pkg::NOM_W-1:0]         nom_q;
	logic [fdpll_pkg::TOL_W-1:0]         tol_q;
	logic [fdpll_pkg::STEP_W-1:0]        step_q;
	logic [fdpll_pkg::TOLSTEP_W-1:0]     tolstep_q;

	logic [fdpll_pkg::TIME_BITS-1:0]     time_q;
	logic [fdpll_pkg::TIME_BITS-1:0]     edge_q;
	logic [fdpll_pkg::PERIOD_W-1:0]      period_q;
	logic                                speed_q;
	logic                                hunt_q;
	logic [1:0]                          run_q;
	logic [1:0]                          fe_q;
	logic [1:0]                          fl_q;
	logic [1:0]                          pc_q;
	logic                                row_q;
	logic [fdpll_pkg::BIN_W-1:0]         bin_q;
	logic [fdpll_pkg::CELLS_W-1:0]       cells_q;

	logic                                out_valid_q;
	logic [fdpll_pkg::M_TDATA_W-1:0]     out_data_q;

	fdpll_pkg::action_t                  in_action;
	logic [fdpll_pkg::IVAL_W-1:0]        in_ival;
	logic                                in_accept;
	logic                                out_free;
	logic [fdpll_pkg::TIME_BITS-1:0]     sum;
	logic                                early;
	logic                                restart_now;
	logic [fdpll_pkg::TIME_BITS-1:0]     rs_edge;
	logic                                behind;
	logic [fdpll_pkg::PERIOD_W-1:0]      eff;
	logic [fdpll_pkg::NOM_W+fdpll_pkg::STEP_MUL_W-1:0] step_prod;
	logic                                lo_ok;
	logic [fdpll_pkg::PERIOD_W-1:0]      lim_hi;
	logic [fdpll_pkg::PERIOD_W+3:0]      edge_prod;

	logic                                upd_speed;
	logic [1:0]                          upd_run;
	logic [1:0]                          upd_fe;
	logic [1:0]                          upd_fl;
	logic [1:0]                          upd_pc;
	logic [fdpll_pkg::PERIOD_W-1:0]      upd_period;
	logic                                upd_row;
	logic                                change;

	logic                                div_start;
	fdpll_pkg::div_req_t                 div_req;
	fdpll_pkg::div_res_t                 div_res;

	fdpll_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	// Input decode and the early test on the running transition time.
	always_comb begin
		in_action   = fdpll_pkg::action_t'(s_axis_tdata[1:0]);
		in_ival     = s_axis_tdata[fdpll_pkg::ACTION_W +: fdpll_pkg::IVAL_W];
		in_accept   = s_axis_tvalid && s_axis_tready;
		out_free    = !out_valid_q || m_axis_tready;
		sum         = time_q + fdpll_pkg::TIME_BITS'(in_ival);
		early       = hunt_q && (sum < edge_q);
		restart_now = in_accept && ((in_action == fdpll_pkg::ACT_RESTART) ||
			((in_action == fdpll_pkg::ACT_FLUX) && early));
		rs_edge     = fdpll_pkg::TIME_BITS'(in_ival) + fdpll_pkg::TIME_BITS'(nom_q >> 1);
		behind      = time_q < edge_q;
		eff         = (period_q == '0) ? fdpll_pkg::PERIOD_W'(1) : period_q;
		step_prod   = nom_q * fdpll_pkg::STEP_MUL;
		edge_prod   = fdpll_pkg::edge_mult(row_q, bin_q) * eff;
	end

	// Divider request: gap behind the window edge over the effective period.
	assign div_req = '{
		start:    div_start,
		dividend: time_q - edge_q,
		divisor:  eff
	};

	// Period bounds from the configured nominal and tolerance.
	always_comb begin
		lim_hi = fdpll_pkg::PERIOD_W'({1'b0, nom_q} + {1'b0, tolstep_q});
		lo_ok  = (nom_q >= tolstep_q) &&
			(period_q > fdpll_pkg::PERIOD_W'(nom_q - tolstep_q));
	end

	// Loop filter: counters, frequency step and phase table row for this slot.
	always_comb begin
		upd_speed  = speed_q;
		upd_run    = run_q;
		upd_fe     = fe_q;
		upd_fl     = fl_q;
		upd_pc     = pc_q;
		upd_period = period_q;
		upd_row    = 1'b1;
		change     = 1'b0;
		if ((bin_q < fdpll_pkg::SLOT_LOCK_LO) || (bin_q > fdpll_pkg::SLOT_LOCK_HI)) begin
			if (((bin_q <= fdpll_pkg::SLOT_EARLY_HI) && !upd_speed) ||
				((bin_q >= fdpll_pkg::SLOT_LATE_LO) && upd_speed)) begin
				upd_speed = !upd_speed;
				upd_pc    = 2'd0;
				upd_run   = 2'd0;
			end
			upd_run = upd_run + 2'd1;
			change  = upd_run >= fdpll_pkg::COUNT_LIMIT;
			if (!change && (bin_q < fdpll_pkg::SLOT_FAR_EARLY)) begin
				upd_fe = upd_fe + 2'd1;
				change = upd_fe >= fdpll_pkg::COUNT_LIMIT;
			end
			if (!change && (bin_q > fdpll_pkg::SLOT_FAR_LATE)) begin
				upd_fl = upd_fl + 2'd1;
				change = upd_fl >= fdpll_pkg::COUNT_LIMIT;
			end
			if (change) begin
				if (upd_speed && lo_ok) begin
					upd_period = period_q - fdpll_pkg::PERIOD_W'(step_q);
				end else if (!upd_speed && (period_q < lim_hi)) begin
					upd_period = period_q + fdpll_pkg::PERIOD_W'(step_q);
				end
				upd_row = 1'b0;
				upd_run = 2'd0;
				upd_pc  = 2'd0;
				upd_fe  = 2'd0;
				upd_fl  = 2'd0;
			end else begin
				upd_pc = upd_pc + 2'd1;
				if (upd_pc >= fdpll_pkg::PHASE_LIMIT) begin
					upd_row = 1'b0;
					upd_pc  = 2'd0;
				end
			end
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdpll_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, input ready and divider start.
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		unique case (state_q)
			fdpll_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && (in_action == fdpll_pkg::ACT_FLUX)) begin
					state_d = fdpll_pkg::ST_CHECK;
				end
			end
			fdpll_pkg::ST_CHECK: begin
				if (behind) begin
					state_d = fdpll_pkg::ST_IDLE;
				end else begin
					div_start = 1'b1;
					state_d   = fdpll_pkg::ST_DIV;
				end
			end
			fdpll_pkg::ST_DIV: begin
				if (div_res.done) begin
					state_d = fdpll_pkg::ST_UPDATE;
				end
			end
			fdpll_pkg::ST_UPDATE: begin
				state_d = fdpll_pkg::ST_EDGE;
			end
			fdpll_pkg::ST_EDGE: begin
				if (out_free) begin
					state_d = fdpll_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fdpll_pkg::ST_IDLE;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nom_q <= fdpll_pkg::NOM_RESET;
			tol_q <= fdpll_pkg::TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fdpll_pkg::REG_NOMINAL:   nom_q <= cfg_data[fdpll_pkg::NOM_W-1:0];
				fdpll_pkg::REG_TOLERANCE: tol_q <= cfg_data[fdpll_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Frequency step and tolerance span, registered from the configured nominal and tolerance.
	always_ff @(posedge clk) begin
		step_q    <= step_prod[fdpll_pkg::STEP_SHIFT +: fdpll_pkg::STEP_W];
		tolstep_q <= tol_q * step_q;
	end

	// Loop state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q   <= '0;
			edge_q   <= fdpll_pkg::TIME_BITS'(fdpll_pkg::NOM_RESET >> 1);
			period_q <= fdpll_pkg::PERIOD_W'(fdpll_pkg::NOM_RESET);
			speed_q  <= 1'b0;
			hunt_q   <= 1'b1;
			run_q    <= '0;
			fe_q     <= '0;
			fl_q     <= '0;
			pc_q     <= '0;
		end else begin
			if (restart_now) begin
				time_q   <= fdpll_pkg::TIME_BITS'(in_ival);
				edge_q   <= rs_edge;
				period_q <= fdpll_pkg::PERIOD_W'(nom_q);
				speed_q  <= 1'b0;
				run_q    <= '0;
				fe_q     <= '0;
				fl_q     <= '0;
				pc_q     <= '0;
			end else if (in_accept && (in_action == fdpll_pkg::ACT_FLUX)) begin
				time_q <= sum;
			end
			if (in_accept && (in_action == fdpll_pkg::ACT_RESTART)) begin
				hunt_q <= 1'b1;
			end else if (in_accept && (in_action == fdpll_pkg::ACT_SYNC)) begin
				hunt_q <= 1'b0;
			end
			if (state_q == fdpll_pkg::ST_UPDATE) begin
				period_q <= upd_period;
				speed_q  <= upd_speed;
				run_q    <= upd_run;
				fe_q     <= upd_fe;
				fl_q     <= upd_fl;
				pc_q     <= upd_pc;
			end
			if ((state_q == fdpll_pkg::ST_EDGE) && out_free) begin
				edge_q <= time_q + fdpll_pkg::TIME_BITS'(edge_prod[fdpll_pkg::PERIOD_W+3:4]);
			end
		end
	end

	// Divider results and the phase table row.
	always_ff @(posedge clk) begin
		if ((state_q == fdpll_pkg::ST_DIV) && div_res.done) begin
			bin_q   <= div_res.bin;
			cells_q <= div_res.cells;
		end
		if (state_q == fdpll_pkg::ST_UPDATE) begin
			row_q <= upd_row;
		end
	end

	// Output register: holds a result until its transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == fdpll_pkg::ST_EDGE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == fdpll_pkg::ST_EDGE) && out_free) begin
			out_data_q <= fdpll_pkg::M_TDATA_W'({period_q, cells_q});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/fdpll_chk.sv =====
`default_nettype none

// Port-level checks of the flux loop.
module fdpll_chk (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic [fdpll_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [fdpll_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

	logic s_accept;
	logic flux_item;

	assign s_accept  = s_axis_tvalid && s_axis_tready;
	assign flux_item = s_axis_tdata[1:0] == fdpll_pkg::ACT_FLUX;

	// A waiting result holds until its transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed while stalled");

	// A flux interval occupies the loop, so the input closes right after it.
	a_flux_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && flux_item) |=> !s_axis_tready)
		else $error("input open right after a flux interval");

	// Restart, sync and unused actions never produce a result.
	a_ctrl_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && !flux_item && !m_axis_tvalid) |=> !m_axis_tvalid)
		else $error("result after a control action");

	// A flux result needs the divider, so none shows during the window check or the start of the divide.
	a_flux_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && flux_item && !m_axis_tvalid) |=> (!m_axis_tvalid ##1 !m_axis_tvalid))
		else $error("flux result came too early");

endmodule

bind floppy_flux_dpll fdpll_chk u_fdpll_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
